/* design/lfpd_pkg.sv */
// Shared types, constants and the line-code decode for the line-follower PID drive.
`timescale 1ns / 1ps

package lfpd_pkg;

    localparam int WIN_DEPTH = 10;
    localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int ERR_MAX   = 5;
    localparam int SUM_W     = $clog2(ERR_MAX * WIN_DEPTH + 1) + 1;
    localparam int GAIN_W    = 12;
    localparam int P_W       = GAIN_W + 1 + 4;
    localparam int D_W       = GAIN_W + 1 + 5;
    localparam int I_W       = GAIN_W + 1 + SUM_W;
    localparam int ADJ_W     = ((I_W > D_W) ? I_W : D_W) + 2;

    // line sensor codes
    localparam logic [3:0] LS_LOST       = 4'd0;
    localparam logic [3:0] LS_FAR_LEFT   = 4'd1;
    localparam logic [3:0] LS_LEFT       = 4'd2;
    localparam logic [3:0] LS_CENTER_A   = 4'd3;
    localparam logic [3:0] LS_END        = 4'd4;
    localparam logic [3:0] LS_CENTER_B   = 4'd5;
    localparam logic [3:0] LS_RIGHT      = 4'd6;
    localparam logic [3:0] LS_FAR_RIGHT  = 4'd7;
    localparam logic [3:0] LS_CENTER_C   = 4'd8;
    localparam logic [3:0] LS_NEAR_LEFT  = 4'd9;
    localparam logic [3:0] LS_NEAR_RIGHT = 4'd10;

    typedef logic signed [3:0]         err_t;
    typedef logic signed [4:0]         diff_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [ADJ_W-1:0]   adj_t;
    typedef logic [WIN_IDX_W-1:0]      slot_t;

    localparam err_t ERR_LOST_POS = 4'sd5;
    localparam err_t ERR_LOST_NEG = -4'sd5;

    typedef enum logic [1:0] {
        KIND_PID,
        KIND_SPIN,
        KIND_IDLE,
        KIND_END
    } kind_t;

    typedef enum logic [2:0] {
        CFG_BASE_SPEED   = 3'd0,
        CFG_KP_GAIN      = 3'd1,
        CFG_KI_GAIN      = 3'd2,
        CFG_KD_GAIN      = 3'd3,
        CFG_SPEED_LIMIT  = 3'd4,
        CFG_SEARCH_SPEED = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [7:0] base_speed;
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_gain;
        logic [GAIN_W-1:0] kd_gain;
        logic [6:0]        speed_limit;
        logic [6:0]        search_speed;
    } cfg_t;

    typedef struct packed {
        logic  en;
        slot_t addr;
    } rd_req_t;

    typedef struct packed {
        kind_t kind;
        logic  spin_pos;
        err_t  err;
        diff_t derr;
        slot_t slot;
    } s1_t;

    typedef struct packed {
        kind_t kind;
        logic  spin_pos;
        err_t  err;
        diff_t derr;
        sum_t  sum;
    } s2_t;

    typedef struct packed {
        kind_t                 kind;
        logic                  spin_pos;
        logic signed [P_W-1:0] p_prod;
        logic signed [I_W-1:0] i_prod;
        logic signed [D_W-1:0] d_prod;
    } s3_t;

    typedef struct packed {
        logic signed [7:0] left_speed;
        logic signed [7:0] right_speed;
        logic              drive_valid;
        logic              end_reached;
    } res_t;

    function automatic err_t map_error(input logic [3:0] code, input err_t prev);
        err_t e;
        e = prev;
        unique case (code)
            LS_FAR_LEFT:   e = -4'sd4;
            LS_LEFT:       e = -4'sd3;
            LS_CENTER_A,
            LS_CENTER_B,
            LS_CENTER_C:   e = 4'sd0;
            LS_RIGHT:      e = 4'sd3;
            LS_FAR_RIGHT:  e = 4'sd4;
            LS_NEAR_LEFT:  e = -4'sd1;
            LS_NEAR_RIGHT: e = 4'sd1;
            default:       e = prev;
        endcase
        return e;
    endfunction

endpackage

/* design/lfpd_front.sv */
// Front stage: line-code decode, error state, window slot pointer and memory read request.
`timescale 1ns / 1ps

module lfpd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [3:0]          line_state,
    output lfpd_pkg::rd_req_t   rd_req,
    output lfpd_pkg::s1_t       s1
);

    lfpd_pkg::err_t  cur_err_reg, cur_err_next;
    lfpd_pkg::err_t  last_err_reg, last_err_next;
    lfpd_pkg::slot_t slot_reg, slot_next;
    lfpd_pkg::s1_t   s1_reg, s1_next;
    lfpd_pkg::err_t  e;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_err_reg  <= '0;
            last_err_reg <= '0;
            slot_reg     <= '0;
        end else begin
            cur_err_reg  <= cur_err_next;
            last_err_reg <= last_err_next;
            slot_reg     <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
    end

    always_comb begin
        cur_err_next  = cur_err_reg;
        last_err_next = last_err_reg;
        slot_next     = slot_reg;
        s1_next       = s1_reg;
        rd_req.en     = 1'b0;
        rd_req.addr   = slot_reg;
        e             = lfpd_pkg::map_error(line_state, cur_err_reg);
        if (accept) begin
            s1_next.spin_pos = 1'b0;
            s1_next.err      = '0;
            s1_next.derr     = '0;
            s1_next.slot     = slot_reg;
            priority if (line_state == lfpd_pkg::LS_END) begin
                s1_next.kind = lfpd_pkg::KIND_END;
            end else if (line_state == lfpd_pkg::LS_LOST) begin
                priority if (last_err_reg > 0) begin
                    cur_err_next     = lfpd_pkg::ERR_LOST_POS;
                    s1_next.kind     = lfpd_pkg::KIND_SPIN;
                    s1_next.spin_pos = 1'b1;
                end else if (last_err_reg < 0) begin
                    cur_err_next     = lfpd_pkg::ERR_LOST_NEG;
                    s1_next.kind     = lfpd_pkg::KIND_SPIN;
                end else begin
                    s1_next.kind     = lfpd_pkg::KIND_IDLE;
                end
                last_err_next = cur_err_next;
            end else begin
                cur_err_next  = e;
                last_err_next = e;
                s1_next.kind  = lfpd_pkg::KIND_PID;
                s1_next.err   = e;
                s1_next.derr  = lfpd_pkg::diff_t'(e) - lfpd_pkg::diff_t'(last_err_reg);
                rd_req.en     = 1'b1;
                if (slot_reg == lfpd_pkg::slot_t'(lfpd_pkg::WIN_DEPTH - 1)) begin
                    slot_next = '0;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
        end
    end

    assign s1 = s1_reg;

endmodule

/* design/lfpd_window.sv */
// Error window memory with per-entry valid bits and the running window sum.
`timescale 1ns / 1ps

module lfpd_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  lfpd_pkg::rd_req_t   rd_req,
    input  lfpd_pkg::s1_t       s1,
    input  logic                step,
    output lfpd_pkg::s2_t       s2
);

    lfpd_pkg::err_t                     win_mem [lfpd_pkg::WIN_DEPTH];
    logic [lfpd_pkg::WIN_DEPTH-1:0]     vld_reg, vld_next;
    lfpd_pkg::err_t                     rd_data_reg;
    logic                               rd_vld_reg;
    lfpd_pkg::sum_t                     sum_reg, sum_next;
    lfpd_pkg::s2_t                      s2_reg, s2_next;
    lfpd_pkg::err_t                     old_err;
    logic                               wr_en;

    assign wr_en   = step && (s1.kind == lfpd_pkg::KIND_PID);
    assign old_err = rd_vld_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_data_reg <= win_mem[rd_req.addr];
            rd_vld_reg  <= vld_reg[rd_req.addr];
        end
        if (wr_en) begin
            win_mem[s1.slot] <= s1.err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            sum_reg <= '0;
        end else begin
            vld_reg <= vld_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            s2_reg <= s2_next;
        end
    end

    always_comb begin
        vld_next = vld_reg;
        sum_next = sum_reg;
        if (wr_en) begin
            vld_next[s1.slot] = 1'b1;
            sum_next = sum_reg + lfpd_pkg::sum_t'(s1.err) - lfpd_pkg::sum_t'(old_err);
        end
        s2_next.kind     = s1.kind;
        s2_next.spin_pos = s1.spin_pos;
        s2_next.err      = s1.err;
        s2_next.derr     = s1.derr;
        s2_next.sum      = sum_next;
    end

    assign s2 = s2_reg;

endmodule

/* design/lfpd_mac.sv */
// Gain products, steering sum, speed clamp and the result register.
`timescale 1ns / 1ps

module lfpd_mac (
    input  logic                aclk,
    input  lfpd_pkg::cfg_t      cfg,
    input  lfpd_pkg::s2_t       s2,
    input  logic                load3,
    input  logic                load_out,
    output lfpd_pkg::res_t      res
);

    lfpd_pkg::s3_t  s3_reg, s3_next;
    lfpd_pkg::res_t res_reg, res_next;

    logic signed [lfpd_pkg::P_W-1:0] kp_x, e_x;
    logic signed [lfpd_pkg::I_W-1:0] ki_x, sum_x;
    logic signed [lfpd_pkg::D_W-1:0] kd_x, de_x;
    lfpd_pkg::adj_t                  adj, base_q8;
    logic signed [7:0]               ss;

    function automatic logic signed [7:0] clamp_trunc(input lfpd_pkg::adj_t x,
                                                      input logic [6:0] limit);
        lfpd_pkg::adj_t lim;
        lfpd_pkg::adj_t y;
        lim = lfpd_pkg::adj_t'({1'b0, limit, 8'h00});
        priority if (x > lim) begin
            y = lim;
        end else if (x < -lim) begin
            y = -lim;
        end else begin
            y = x;
        end
        if (y < 0) begin
            y = y + lfpd_pkg::adj_t'(255);
        end
        return y[15:8];
    endfunction

    always_comb begin
        kp_x  = lfpd_pkg::P_W'({1'b0, cfg.kp_gain});
        e_x   = lfpd_pkg::P_W'(s2.err);
        ki_x  = lfpd_pkg::I_W'({1'b0, cfg.ki_gain});
        sum_x = lfpd_pkg::I_W'(s2.sum);
        kd_x  = lfpd_pkg::D_W'({1'b0, cfg.kd_gain});
        de_x  = lfpd_pkg::D_W'(s2.derr);
        s3_next.kind     = s2.kind;
        s3_next.spin_pos = s2.spin_pos;
        s3_next.p_prod   = kp_x * e_x;
        s3_next.i_prod   = ki_x * sum_x;
        s3_next.d_prod   = kd_x * de_x;
    end

    always_ff @(posedge aclk) begin
        if (load3) begin
            s3_reg <= s3_next;
        end
    end

    always_comb begin
        adj = lfpd_pkg::adj_t'(s3_reg.p_prod) + lfpd_pkg::adj_t'(s3_reg.i_prod)
            + lfpd_pkg::adj_t'(s3_reg.d_prod);
        base_q8 = lfpd_pkg::adj_t'(cfg.base_speed) <<< 8;
        ss      = {1'b0, cfg.search_speed};
        res_next = '0;
        unique case (s3_reg.kind)
            lfpd_pkg::KIND_PID: begin
                res_next.left_speed  = clamp_trunc(base_q8 - adj, cfg.speed_limit);
                res_next.right_speed = clamp_trunc(base_q8 + adj, cfg.speed_limit);
                res_next.drive_valid = 1'b1;
            end
            lfpd_pkg::KIND_SPIN: begin
                res_next.left_speed  = s3_reg.spin_pos ? -ss : ss;
                res_next.right_speed = s3_reg.spin_pos ? ss : -ss;
                res_next.drive_valid = 1'b1;
            end
            lfpd_pkg::KIND_END: begin
                res_next.end_reached = 1'b1;
            end
            default: begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* design/line_follow_pid_drive.sv */
// Top level of the line-follower PID drive: configuration, pipeline control, ports.
// Usage:
//   Input channel s_*: one 4-bit line sensor code per request (s_valid/s_ready).
//   Result channel m_*: one result per request with left/right speeds, drive flag
//   and end flag (m_valid/m_ready), in request order.
//   Configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle;
//   indexes beyond search_speed are ignored. Write only while the block is idle.
// Pipeline: a request passes through four register stages (decode and window read,
//   window write and sum update, gain products, steering sum and clamp) before
//   m_valid rises.
// Throughput: one request per cycle unless the output stalls; the error window
//   memory is read at acceptance and written as the request leaves the first
//   stage, always at a different entry from the read issued in that cycle.
// Reset: configuration returns to defaults, error state, window pointer and sum
//   clear, and the per-entry window valid bits clear together (no sweep).
// Stall: with m_ready low the result register holds; requests are still taken
//   until the four pipeline stages fill, then s_ready drops.
`timescale 1ns / 1ps

module line_follow_pid_drive (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_line_state,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [7:0] m_left_speed,
    output logic signed [7:0] m_right_speed,
    output logic              m_drive_valid,
    output logic              m_end_reached,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [11:0]       cfg_wdata
);

    lfpd_pkg::cfg_t    cfg_reg, cfg_next;
    lfpd_pkg::rd_req_t rd_req;
    lfpd_pkg::s1_t     s1;
    lfpd_pkg::s2_t     s2;
    lfpd_pkg::res_t    res;

    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next, mv_reg, mv_next;
    logic en1, en2, en3, en_out, accept, step, load3, load_out;

    assign en_out   = !mv_reg || m_ready;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_ready  = en1;
    assign accept   = s_valid && en1;
    assign step     = v1_reg && en2;
    assign load3    = v2_reg && en3;
    assign load_out = v3_reg && en_out;

    always_comb begin
        v1_next = accept || (v1_reg && !en2);
        v2_next = step || (v2_reg && !en3);
        v3_next = load3 || (v3_reg && !en_out);
        mv_next = load_out || (mv_reg && !m_ready);
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                lfpd_pkg::CFG_BASE_SPEED:   cfg_next.base_speed   = cfg_wdata[7:0];
                lfpd_pkg::CFG_KP_GAIN:      cfg_next.kp_gain      = cfg_wdata;
                lfpd_pkg::CFG_KI_GAIN:      cfg_next.ki_gain      = cfg_wdata;
                lfpd_pkg::CFG_KD_GAIN:      cfg_next.kd_gain      = cfg_wdata;
                lfpd_pkg::CFG_SPEED_LIMIT:  cfg_next.speed_limit  = cfg_wdata[6:0];
                lfpd_pkg::CFG_SEARCH_SPEED: cfg_next.search_speed = cfg_wdata[6:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_speed   <= 8'sd40;
            cfg_reg.kp_gain      <= 12'd59;
            cfg_reg.ki_gain      <= 12'd0;
            cfg_reg.kd_gain      <= 12'd128;
            cfg_reg.speed_limit  <= 7'd80;
            cfg_reg.search_speed <= 7'd35;
            v1_reg               <= 1'b0;
            v2_reg               <= 1'b0;
            v3_reg               <= 1'b0;
            mv_reg               <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            v3_reg  <= v3_next;
            mv_reg  <= mv_next;
        end
    end

    lfpd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .line_state (s_line_state),
        .rd_req     (rd_req),
        .s1         (s1)
    );

    lfpd_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rd_req),
        .s1      (s1),
        .step    (step),
        .s2      (s2)
    );

    lfpd_mac u_mac (
        .aclk     (aclk),
        .cfg      (cfg_reg),
        .s2       (s2),
        .load3    (load3),
        .load_out (load_out),
        .res      (res)
    );

    assign m_valid       = mv_reg;
    assign m_left_speed  = res.left_speed;
    assign m_right_speed = res.right_speed;
    assign m_drive_valid = res.drive_valid;
    assign m_end_reached = res.end_reached;

endmodule
